>>> rtl/core/sample_standard_deviation_core_assert.svh
// Assertion macros for the sample standard deviation core checker.
// Each macro expands to one labeled concurrent assertion clocked on clk.
`ifndef SAMPLE_STANDARD_DEVIATION_CORE_ASSERT_SVH
`define SAMPLE_STANDARD_DEVIATION_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SSD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssd assertion failed");

// Next-cycle implication, disabled during reset.
`define SSD_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssd assertion failed");

`endif

>>> rtl/core/ssd_pkg.sv
`timescale 1ns / 1ps
// Shared widths, status codes, ALU opcodes and the statistics bundle
// for the sample standard deviation core. No dependencies.
package ssd_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CNT_W    = 16;
    localparam int SUM_W    = 32;
    localparam int SQ_W     = 47;
    localparam int ACC_W    = 64;
    localparam int DEN_W    = 32;
    localparam int STEP_W   = 5;
    localparam int DEV_W    = 16;
    localparam int STAT_W   = 2;

    localparam logic [CNT_W-1:0] MAX_SAMPLES = 16'd65535;

    localparam logic [STAT_W-1:0] STAT_OK  = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FEW = 2'd1;
    localparam logic [STAT_W-1:0] STAT_OVF = 2'd2;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        logic [CNT_W-1:0] n;
        logic [SQ_W-1:0]  sum_sq;
        logic [SUM_W-1:0] sum_mag;
    } ssd_stats_t;

endpackage

>>> rtl/core/ssd_alu.sv
`timescale 1ns / 1ps
// Shared 64-bit add/subtract unit with borrow out.
// Depends on ssd_pkg for widths and opcodes.
module ssd_alu (
    input  logic [ssd_pkg::ACC_W-1:0] a,
    input  logic [ssd_pkg::ACC_W-1:0] b,
    input  ssd_pkg::alu_op_t          op,
    output logic [ssd_pkg::ACC_W-1:0] sum,
    output logic                      borrow
);
    import ssd_pkg::*;

    logic [ACC_W:0] wide;

    always_comb
    begin
        case (op)
            ALU_ADD: wide = {1'b0, a} + {1'b0, b};
            ALU_SUB: wide = {1'b0, a} - {1'b0, b};
            default: wide = '0;
        endcase
    end

    assign sum    = wide[ACC_W-1:0];
    assign borrow = (op == ALU_SUB) & wide[ACC_W];

endmodule

>>> rtl/core/ssd_finish.sv
`timescale 1ns / 1ps
// Final sequencer: n*(n-1), n*S2, S1^2, subtract, divide and square root,
// all stepped through one shared ssd_alu. Depends on ssd_pkg and ssd_alu.
module ssd_finish (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  ssd_pkg::ssd_stats_t       stats,
    output logic                      done,
    output logic [ssd_pkg::DEV_W-1:0] root
);
    import ssd_pkg::*;

    typedef enum logic [2:0] {
        F_IDLE,
        F_DEN,
        F_S2,
        F_S1,
        F_SUB,
        F_DIV,
        F_SQRT,
        F_DONE
    } fin_state_t;

    fin_state_t        state_reg;
    logic [STEP_W-1:0] cnt_reg;

    logic [CNT_W-1:0] n_reg;
    logic [CNT_W-1:0] nm1_reg;
    logic [SQ_W-1:0]  s2_reg;
    logic [SUM_W-1:0] s1_reg;
    logic [DEN_W-1:0] den_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] p_reg;

    logic [ACC_W-1:0] alu_a;
    logic [ACC_W-1:0] alu_b;
    alu_op_t          alu_op;
    logic [ACC_W-1:0] alu_sum;
    logic             alu_borrow;
    logic [31:0]      sq_bit;
    logic             last_step;

    assign sq_bit    = 32'd1 << {cnt_reg[3:0], 1'b0};
    assign last_step = (cnt_reg == '0);

    always_comb
    begin
        alu_a  = '0;
        alu_b  = '0;
        alu_op = ALU_ADD;
        case (state_reg)
            F_DEN:
            begin
                alu_a = {acc_reg[ACC_W-2:0], 1'b0};
                alu_b = n_reg[cnt_reg[3:0]] ? ACC_W'(nm1_reg) : '0;
            end
            F_S2:
            begin
                alu_a = {acc_reg[ACC_W-2:0], 1'b0};
                alu_b = n_reg[cnt_reg[3:0]] ? ACC_W'(s2_reg) : '0;
            end
            F_S1:
            begin
                alu_a = {acc_reg[ACC_W-2:0], 1'b0};
                alu_b = s1_reg[cnt_reg] ? ACC_W'(s1_reg) : '0;
            end
            F_SUB:
            begin
                alu_a  = p_reg;
                alu_b  = acc_reg;
                alu_op = ALU_SUB;
            end
            F_DIV:
            begin
                alu_a  = {31'd0, p_reg[31:0], acc_reg[31]};
                alu_b  = {32'd0, den_reg};
                alu_op = ALU_SUB;
            end
            F_SQRT:
            begin
                alu_a  = p_reg;
                alu_b  = {32'd0, acc_reg[31:0] | sq_bit};
                alu_op = ALU_SUB;
            end
            default:
            begin
                alu_a  = '0;
                alu_b  = '0;
                alu_op = ALU_ADD;
            end
        endcase
    end

    ssd_alu u_alu (
        .a      (alu_a),
        .b      (alu_b),
        .op     (alu_op),
        .sum    (alu_sum),
        .borrow (alu_borrow)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                F_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= F_DEN;
                        cnt_reg   <= STEP_W'(CNT_W - 1);
                    end
                end
                F_DEN:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (last_step)
                    begin
                        state_reg <= F_S2;
                        cnt_reg   <= STEP_W'(CNT_W - 1);
                    end
                end
                F_S2:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (last_step)
                    begin
                        state_reg <= F_S1;
                        cnt_reg   <= STEP_W'(SUM_W - 1);
                    end
                end
                F_S1:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (last_step)
                    begin
                        state_reg <= F_SUB;
                    end
                end
                F_SUB:
                begin
                    state_reg <= F_DIV;
                    cnt_reg   <= STEP_W'(DEN_W - 1);
                end
                F_DIV:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (last_step)
                    begin
                        state_reg <= F_SQRT;
                        cnt_reg   <= STEP_W'(DEV_W - 1);
                    end
                end
                F_SQRT:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (last_step)
                    begin
                        state_reg <= F_DONE;
                    end
                end
                F_DONE:
                begin
                    state_reg <= F_IDLE;
                end
                default:
                begin
                    state_reg <= F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                if (start)
                begin
                    n_reg   <= stats.n;
                    nm1_reg <= stats.n - 1'b1;
                    s2_reg  <= stats.sum_sq;
                    s1_reg  <= stats.sum_mag;
                    acc_reg <= '0;
                end
            end
            F_DEN:
            begin
                acc_reg <= alu_sum;
                if (last_step)
                begin
                    den_reg <= alu_sum[DEN_W-1:0];
                    acc_reg <= '0;
                end
            end
            F_S2:
            begin
                acc_reg <= alu_sum;
                if (last_step)
                begin
                    p_reg   <= alu_sum;
                    acc_reg <= '0;
                end
            end
            F_S1:
            begin
                acc_reg <= alu_sum;
            end
            F_SUB:
            begin
                // numerator in acc, its upper half seeds the remainder
                acc_reg <= alu_sum;
                p_reg   <= {32'd0, alu_sum[63:32]};
            end
            F_DIV:
            begin
                acc_reg <= {acc_reg[ACC_W-2:0], ~alu_borrow};
                if (!alu_borrow)
                begin
                    p_reg <= {32'd0, alu_sum[31:0]};
                end
                else
                begin
                    p_reg <= {32'd0, p_reg[30:0], acc_reg[31]};
                end
                if (last_step)
                begin
                    // hand the quotient to the root as its radicand
                    p_reg   <= {32'd0, acc_reg[30:0], ~alu_borrow};
                    acc_reg <= '0;
                end
            end
            F_SQRT:
            begin
                if (!alu_borrow)
                begin
                    p_reg   <= alu_sum;
                    acc_reg <= {32'd0, (acc_reg[31:0] >> 1) | sq_bit};
                end
                else
                begin
                    acc_reg <= {32'd0, acc_reg[31:0] >> 1};
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign done = (state_reg == F_DONE);
    assign root = acc_reg[DEV_W-1:0];

endmodule

>>> rtl/core/ssd_accum.sv
`timescale 1ns / 1ps
// Running count, sum and sum of squares of the accepted samples.
// Depends on ssd_pkg for widths, the sample limit and the stats bundle.
module ssd_accum (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                take,
    input  logic signed [ssd_pkg::SAMPLE_W-1:0] sample,
    input  logic                                clear,
    output ssd_pkg::ssd_stats_t                 stats,
    output logic                                overflow
);
    import ssd_pkg::*;

    logic [SAMPLE_W-1:0]   raw;
    logic [SAMPLE_W-1:0]   mag;
    logic [2*SAMPLE_W-1:0] sq_full;

    logic                    pend_reg;
    logic [SAMPLE_W-1:0]     samp_reg;
    logic [2*SAMPLE_W-2:0]   sq_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [SQ_W-1:0]         sqsum_reg;
    logic                    ovf_reg;

    assign raw     = sample;
    assign mag     = raw[SAMPLE_W-1] ? (~raw + 1'b1) : raw;
    assign sq_full = mag * mag;

    // square the incoming sample now, fold it in on the next cycle
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            samp_reg <= raw;
            sq_reg   <= sq_full[2*SAMPLE_W-2:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 1'b0;
            count_reg <= '0;
            sum_reg   <= '0;
            sqsum_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else if (clear)
        begin
            pend_reg  <= 1'b0;
            count_reg <= '0;
            sum_reg   <= '0;
            sqsum_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            pend_reg <= take;
            if (pend_reg)
            begin
                if (count_reg < MAX_SAMPLES)
                begin
                    count_reg <= count_reg + 1'b1;
                    sum_reg   <= sum_reg
                               + {{(SUM_W-SAMPLE_W){samp_reg[SAMPLE_W-1]}}, samp_reg};
                    sqsum_reg <= sqsum_reg + SQ_W'(sq_reg);
                end
                else
                begin
                    ovf_reg <= 1'b1;
                end
            end
        end
    end

    assign stats.n       = count_reg;
    assign stats.sum_sq  = sqsum_reg;
    assign stats.sum_mag = sum_reg[SUM_W-1] ? (~sum_reg + 1'b1) : sum_reg;
    assign overflow      = ovf_reg;

endmodule

>>> rtl/core/sample_standard_deviation_core.sv
`timescale 1ns / 1ps
// Sample standard deviation core: input/output control and result register.
// Depends on ssd_pkg, ssd_accum and ssd_finish.
//
// Input channel: sample (signed Q7.8) and last, handshaken by in_valid and
// in_ready. Output channel: std_dev (unsigned Q8.8, truncated), sample_count
// and status, handshaken by out_valid and out_ready.
// A sample that is not marked last is taken as a request, then its square and
// value are added in the next cycle; in_ready returns after that. A last
// sample with two or more samples in the set produces its result through the
// one shared 64-bit adder: 16 + 16 + 32 shift-add multiply steps, one subtract,
// 32 restoring divide steps and 16 square root steps. With fewer than two
// samples the result (status 1, std_dev 0) is formed without the adder.
// Samples past the limit are dropped and the result carries status 2.
// A finished result waits in the output register while out_ready is low;
// further samples of the next set are taken meanwhile, and the next result
// holds until the register frees up. Reset clears all sums, the count and
// out_valid.
module sample_standard_deviation_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [ssd_pkg::SAMPLE_W-1:0] sample,
    input  logic                                last,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [ssd_pkg::DEV_W-1:0]           std_dev,
    output logic [ssd_pkg::CNT_W-1:0]           sample_count,
    output logic [ssd_pkg::STAT_W-1:0]          status
);
    import ssd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_CHECK,
        ST_WAIT,
        ST_OUT
    } top_state_t;

    top_state_t state_reg;
    top_state_t state_next;
    logic       out_valid_reg;

    logic              last_reg;
    logic [DEV_W-1:0]  res_dev_reg;
    logic [CNT_W-1:0]  res_cnt_reg;
    logic [STAT_W-1:0] res_stat_reg;
    logic [DEV_W-1:0]  std_dev_reg;
    logic [CNT_W-1:0]  sample_count_reg;
    logic [STAT_W-1:0] status_reg;

    ssd_stats_t       stats;
    logic             overflow;
    logic             take;
    logic             few;
    logic             start;
    logic             clear;
    logic             out_free;
    logic             fin_done;
    logic [DEV_W-1:0] fin_root;

    assign in_ready = (state_reg == ST_IDLE);
    assign take     = in_valid & in_ready;
    assign few      = (stats.n < CNT_W'(2));
    assign start    = (state_reg == ST_CHECK) & ~few;
    assign out_free = ~out_valid_reg | out_ready;
    assign clear    = (state_reg == ST_OUT) & out_free;

    ssd_accum u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .sample   (sample),
        .clear    (clear),
        .stats    (stats),
        .overflow (overflow)
    );

    ssd_finish u_finish (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stats (stats),
        .done  (fin_done),
        .root  (fin_root)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  state_next = take ? ST_ACC : ST_IDLE;
            ST_ACC:   state_next = last_reg ? ST_CHECK : ST_IDLE;
            ST_CHECK: state_next = few ? ST_OUT : ST_WAIT;
            ST_WAIT:  state_next = fin_done ? ST_OUT : ST_WAIT;
            ST_OUT:   state_next = out_free ? ST_IDLE : ST_OUT;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (clear)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            last_reg <= last;
        end
        if (state_reg == ST_CHECK)
        begin
            res_cnt_reg <= stats.n;
            res_dev_reg <= '0;
            if (few)
            begin
                res_stat_reg <= STAT_FEW;
            end
            else if (overflow)
            begin
                res_stat_reg <= STAT_OVF;
            end
            else
            begin
                res_stat_reg <= STAT_OK;
            end
        end
        if ((state_reg == ST_WAIT) && fin_done)
        begin
            res_dev_reg <= fin_root;
        end
        // hold the result until the output register frees up
        if (clear)
        begin
            std_dev_reg      <= res_dev_reg;
            sample_count_reg <= res_cnt_reg;
            status_reg       <= res_stat_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign std_dev      = std_dev_reg;
    assign sample_count = sample_count_reg;
    assign status       = status_reg;

endmodule

>>> rtl/core/ssd_check.sv
`timescale 1ns / 1ps
// Port-level checker for the sample standard deviation core, bound to the top.
// Depends on ssd_pkg and sample_standard_deviation_core_assert.svh.
`include "sample_standard_deviation_core_assert.svh"

module ssd_check (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         in_valid,
    input logic                         in_ready,
    input logic                         out_valid,
    input logic                         out_ready,
    input logic [ssd_pkg::DEV_W-1:0]    std_dev,
    input logic [ssd_pkg::CNT_W-1:0]    sample_count,
    input logic [ssd_pkg::STAT_W-1:0]   status
);
    import ssd_pkg::*;

    // each taken sample request drops in_ready in the next cycle
    `SSD_ASSERT_NXT(a_busy_after_req, in_valid && in_ready, !in_ready)
    `SSD_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(std_dev) && $stable(sample_count) && $stable(status))
    `SSD_ASSERT_IMP(a_few_zero, out_valid && status == STAT_FEW, std_dev == '0 && sample_count < 16'd2)
    `SSD_ASSERT_IMP(a_ok_count, out_valid && status == STAT_OK, sample_count >= 16'd2)

endmodule

bind sample_standard_deviation_core ssd_check u_ssd_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .std_dev      (std_dev),
    .sample_count (sample_count),
    .status       (status)
);

>>> dv/tb_sample_standard_deviation_core.sv
`timescale 1ns / 1ps
// Self-checking bench for sample_standard_deviation_core: streams sample sets,
// predicts each set's deviation, count and status, and compares every result.
// Depends on ssd_pkg and the core RTL only.
module tb_sample_standard_deviation_core;
    import ssd_pkg::*;

    localparam int RX_HOLD_CYCLES = 800;
    localparam int SETTLE_CYCLES  = 300;

    typedef struct {
        logic [SAMPLE_W-1:0] value;
        logic                is_last;
    } sample_req_t;

    typedef struct {
        logic [DEV_W-1:0]  dev;
        logic [CNT_W-1:0]  count;
        logic [STAT_W-1:0] stat;
    } set_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample = '0;
    logic                       last = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic [DEV_W-1:0]           std_dev;
    logic [CNT_W-1:0]           sample_count;
    logic [STAT_W-1:0]          status;

    sample_req_t sample_queue[$];
    set_result_t pending_deviations[$];

    // running statistics of the set in flight
    int unsigned     set_count = 0;
    longint          set_sum = 0;
    longint unsigned set_square_sum = 0;
    bit              set_overflow = 1'b0;

    int  mismatch_count = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    bit  in_taken = 1'b0;
    bit  rx_hold = 1'b0;
    event rx_hold_go;

    sample_standard_deviation_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .sample       (sample),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .std_dev      (std_dev),
        .sample_count (sample_count),
        .status       (status)
    );

    always #10 clk = ~clk;

    task automatic flag_error(input string what);
        mismatch_count++;
        if (mismatch_count <= 10)
        begin
            $display("ERROR at %0t ns: %s", $time, what);
        end
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want)
        begin
            flag_error($sformatf("%s expected %0d, got %0d", name, want, got));
        end
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= x)
            begin
                root = trial;
            end
        end
        return root;
    endfunction

    // Fold one accepted sample into the set; on the last one, queue its result.
    function automatic void fold_sample(input logic [SAMPLE_W-1:0] raw,
                                        input logic is_last);
        longint          v;
        longint unsigned n;
        longint unsigned sum_mag;
        longint unsigned spread;
        longint unsigned root;
        set_result_t     r;
        v = longint'($signed(raw));
        if (set_count < MAX_SAMPLES)
        begin
            set_count++;
            set_sum += v;
            set_square_sum += longint'(v * v);
        end
        else
        begin
            set_overflow = 1'b1;
        end
        if (is_last)
        begin
            r.count = set_count[CNT_W-1:0];
            if (set_count < 2)
            begin
                r.dev  = '0;
                r.stat = STAT_FEW;
            end
            else
            begin
                n       = set_count;
                sum_mag = (set_sum < 0) ? -set_sum : set_sum;
                spread  = n * set_square_sum - sum_mag * sum_mag;
                root    = int_sqrt(spread / (n * (n - 1)));
                r.dev   = root[DEV_W-1:0];
                r.stat  = set_overflow ? STAT_OVF : STAT_OK;
            end
            pending_deviations.push_back(r);
            set_count      = 0;
            set_sum        = 0;
            set_square_sum = 0;
            set_overflow   = 1'b0;
        end
    endfunction

    // Check results, then record requests taken at this edge.
    always @(posedge clk)
    begin : monitor
        set_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (pending_deviations.size() == 0)
                begin
                    flag_error("result with no set outstanding");
                end
                else
                begin
                    want = pending_deviations.pop_front();
                    check_field("std_dev", want.dev, std_dev);
                    check_field("sample_count", want.count, sample_count);
                    check_field("status", 16'(want.stat), 16'(status));
                end
            end
            in_taken = in_valid && in_ready;
            if (in_taken)
            begin
                fold_sample(sample, last);
                sample_queue.delete(0);
            end
        end
    end

    // Hold the request until taken, then offer the next one or idle.
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || in_taken)
        begin
            if (sample_queue.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                sample   <= sample_queue[0].value;
                last     <= sample_queue[0].is_last;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off, counted here so the block backs up into its input.
    initial
    begin
        forever
        begin
            @(rx_hold_go);
            rx_hold = 1'b1;
            repeat (RX_HOLD_CYCLES) @(posedge clk);
            rx_hold = 1'b0;
        end
    end

    task automatic queue_sample(input logic [SAMPLE_W-1:0] value, input logic is_last);
        sample_req_t req;
        req.value   = value;
        req.is_last = is_last;
        sample_queue.push_back(req);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] base);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 40)
        begin
            return SAMPLE_W'($urandom_range(65535));
        end
        else if (r < 60)
        begin
            return SAMPLE_W'($urandom_range(600)) - SAMPLE_W'(300);
        end
        else if (r < 75)
        begin
            case ($urandom_range(4))
                0: return 16'h8000;
                1: return 16'h7FFF;
                2: return 16'h8001;
                3: return 16'hFFFF;
                default: return 16'h0000;
            endcase
        end
        return base + SAMPLE_W'($urandom_range(255));
    endfunction

    // Queue whole sets, each closed by a last-marked sample.
    task automatic queue_random_sets(input int n_items, input bit short_sets);
        int produced;
        int size;
        int r;
        logic [SAMPLE_W-1:0] base;
        produced = 0;
        while (produced < n_items)
        begin
            r = $urandom_range(99);
            if (short_sets)
                size = $urandom_range(4, 2);
            else if (r < 10)
                size = 1;
            else if (r < 80)
                size = $urandom_range(8, 2);
            else if (r < 96)
                size = $urandom_range(40, 9);
            else
                size = $urandom_range(200, 41);
            base = SAMPLE_W'($urandom_range(65535));
            for (int j = 0; j < size; j++)
            begin
                queue_sample(pick_sample(base), j == size - 1);
            end
            produced += size;
        end
    endtask

    task automatic drain();
        while (sample_queue.size() != 0 || pending_deviations.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int n_items);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        queue_random_sets(n_items, 1'b0);
        drain();
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // directed sets: single sample, full-scale spread, zero spread, small values
        queue_sample(16'h8000, 1'b1);
        queue_sample(16'h8000, 1'b0);
        queue_sample(16'h7FFF, 1'b1);
        queue_sample(16'h7FFF, 1'b0);
        queue_sample(16'h7FFF, 1'b1);
        queue_sample(16'h0000, 1'b0);
        queue_sample(16'hFFFF, 1'b0);
        queue_sample(16'h0001, 1'b1);
        queue_sample(16'h5555, 1'b0);
        queue_sample(16'hAAAA, 1'b0);
        queue_sample(16'h0100, 1'b0);
        queue_sample(16'hFF00, 1'b1);
        for (int i = 0; i < 5; i++)
        begin
            queue_sample(16'h8000, i == 4);
        end
        queue_sample(16'h0000, 1'b1);
        for (int i = 1; i <= 4; i++)
        begin
            queue_sample(SAMPLE_W'(i * 256), i == 4);
        end
        drain();

        run_phase(0, 0, 150);

        // back up the output while short sets keep arriving
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random_sets(80, 1'b1);
        -> rx_hold_go;
        drain();

        run_phase(61, 0, 200);
        run_phase(0, 61, 200);
        run_phase(9, 9, 200);
        run_phase(0, 0, 100);

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_deviations.size() != 0)
        begin
            flag_error($sformatf("%0d results never arrived", pending_deviations.size()));
        end
        if (mismatch_count == 0)
        begin
            $display("sample_standard_deviation_core: match");
        end
        else
        begin
            $display("sample_standard_deviation_core: mismatch");
        end
        $finish;
    end

    initial
    begin
        #25_000_000;
        $display("sample_standard_deviation_core: mismatch");
        $finish;
    end

endmodule
